/* hw/rtl/egd_pkg.sv */
// egd_pkg: shared codes, widths and defaults for the elevator group dispatcher
`default_nettype none

package egd_pkg;

	// default build size
	localparam int NUM_CARS_DEF   = 3;
	localparam int NUM_FLOORS_DEF = 16;

	// fixed field widths of the request and result words
	localparam int KIND_W  = 2;
	localparam int FLOOR_W = 4;
	localparam int CAR_W   = 2;
	localparam int EVENT_W = 2;

	typedef logic [1:0]         dir_t;
	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [EVENT_W-1:0] event_t;

	// car travel direction
	localparam dir_t DIR_UP   = 2'd0;
	localparam dir_t DIR_DOWN = 2'd1;
	localparam dir_t DIR_IDLE = 2'd2;

	// request kinds
	localparam kind_t KIND_HALL = 2'd0;
	localparam kind_t KIND_CAR  = 2'd1;
	localparam kind_t KIND_TICK = 2'd2;

	// result events
	localparam event_t EV_ASSIGNED   = 2'd0;
	localparam event_t EV_UNASSIGNED = 2'd1;
	localparam event_t EV_POSITION   = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/egd_req_if.sv */
// egd_req_if: request channel (hall call, car call or tick)
`default_nettype none

interface egd_req_if
	import egd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [FLOOR_W-1:0] floor;
	logic               dir_down;
	logic [CAR_W-1:0]   car;

	modport source (output valid, output kind, output floor, output dir_down, output car,
		input ready);
	modport sink (input valid, input kind, input floor, input dir_down, input car,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/egd_res_if.sv */
// egd_res_if: result channel (assignment or car position report)
`default_nettype none

interface egd_res_if
	import egd_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [EVENT_W-1:0] event_res;
	logic [CAR_W-1:0]   car_index;
	logic [FLOOR_W-1:0] at_floor;
	logic               stopped;
	logic               last;

	modport source (output valid, output event_res, output car_index, output at_floor,
		output stopped, output last, input ready);
	modport sink (input valid, input event_res, input car_index, input at_floor,
		input stopped, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/elevator_group_dispatcher_top.sv */
// elevator_group_dispatcher_top: nearest-car group dispatcher with a one-car-per-cycle scan
//
//  channel | dir | handshake    | word
//  --------+-----+--------------+------------------------------------------
//  req     | in  | valid/ready  | kind, floor, dir_down, car
//  res     | out | valid/ready  | event_res, car_index, at_floor, stopped, last
//
// one car is visited per cycle by a shared compare/step unit under a small sequencer, save
// in a tick; a hall call scans every car then assigns, a car call assigns directly
// tick: each car in turn, each busy car waiting in place for a free output register
// req.ready is high only while idle; one output register decouples res from the sequencer
// arst_n clears all cars to floor 0, idle, no targets
`default_nettype none

module elevator_group_dispatcher_top
	import egd_pkg::*;
#(
	parameter int NUM_CARS   = NUM_CARS_DEF,
	parameter int NUM_FLOORS = NUM_FLOORS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	egd_req_if.sink   req,
	egd_res_if.source res
);

	localparam int CW = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
	localparam int FW = $clog2(NUM_FLOORS);
	localparam logic [CW-1:0] LAST_CAR  = CW'(NUM_CARS - 1);
	localparam logic [FW-1:0] TOP_FLOOR = FW'(NUM_FLOORS - 1);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_ASSIGN = 2'd2;
	localparam logic [1:0] S_TICK   = 2'd3;

	// mask of floors at or below flr
	function automatic logic [NUM_FLOORS-1:0] le_mask(input logic [FW-1:0] flr);
		logic [NUM_FLOORS-1:0] m;
		for (int i = 0; i < NUM_FLOORS; i++) begin
			m[i] = (i <= int'(flr));
		end
		return m;
	endfunction

	// direction follows the lowest target: up only if every target lies above the car
	function automatic dir_t dir_of(input logic [NUM_FLOORS-1:0] tgt,
		input logic [FW-1:0] flr);
		dir_t d;
		if (tgt == '0) begin
			d = DIR_IDLE;
		end else if ((tgt & le_mask(flr)) == '0) begin
			d = DIR_UP;
		end else begin
			d = DIR_DOWN;
		end
		return d;
	endfunction

	// car state
	logic [FW-1:0]         car_flr_q [NUM_CARS];
	dir_t                  car_dir_q [NUM_CARS];
	logic [NUM_FLOORS-1:0] car_tgt_q [NUM_CARS];

	// sequencer and scan state
	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          hit_q;
	logic [CW-1:0] best_q;
	logic [FW-1:0] bestd_q;
	logic          idle_hit_q;
	logic [CW-1:0] idle_idx_q;
	logic          ok_q;

	// latched request word
	kind_t            kind_q;
	logic [FW-1:0]    fl_q;
	dir_t             dir_q;
	logic [CAR_W-1:0] car_in_q;

	// output register
	logic               out_valid_q;
	event_t             out_ev_q;
	logic [CAR_W-1:0]   out_idx_q;
	logic [FLOOR_W-1:0] out_flr_q;
	logic               out_stop_q;
	logic               out_last_q;

	logic [FW-1:0]         cur_flr;
	dir_t                  cur_dir;
	logic [NUM_FLOORS-1:0] cur_tgt;
	logic                  cur_busy;
	logic [FW-1:0]         req_fl;
	logic                  serves;
	logic [FW-1:0]         gap;
	logic                  hit_n;
	logic [CW-1:0]         best_n;
	logic                  idle_hit_n;
	logic [CW-1:0]         idle_idx_n;
	logic [NUM_FLOORS-1:0] add_tgt;
	logic [FW-1:0]         nxt_flr;
	logic                  arrive;
	logic [NUM_FLOORS-1:0] tick_tgt;
	logic                  higher_busy;
	logic                  out_free;
	logic                  load;
	logic                  wr_en;
	logic [FW-1:0]         wr_flr;
	logic [NUM_FLOORS-1:0] wr_tgt;
	event_t                ld_ev;
	logic [CAR_W-1:0]      ld_idx;

	// selected car
	assign cur_flr  = car_flr_q[cnt_q];
	assign cur_dir  = car_dir_q[cnt_q];
	assign cur_tgt  = car_tgt_q[cnt_q];
	assign cur_busy = (cur_dir != DIR_IDLE);

	// requested floor, saturated at the top floor
	assign req_fl = (int'(req.floor) > NUM_FLOORS - 1) ? TOP_FLOOR : FW'(req.floor);

	// shared compare unit: does this car serve the call, and how far away is it
	always_comb begin
		serves = (cur_dir == dir_q) &&
			(((dir_q == DIR_UP) && (fl_q > cur_flr)) ||
			((dir_q == DIR_DOWN) && (fl_q < cur_flr)));
		gap = (fl_q > cur_flr) ? (fl_q - cur_flr) : (cur_flr - fl_q);
		hit_n      = hit_q;
		best_n     = best_q;
		idle_hit_n = idle_hit_q;
		idle_idx_n = idle_idx_q;
		if (serves && (!hit_q || (gap < bestd_q))) begin
			hit_n  = 1'b1;
			best_n = cnt_q;
		end
		if (!idle_hit_q && !cur_busy) begin
			idle_hit_n = 1'b1;
			idle_idx_n = cnt_q;
		end
	end

	// new target set for a call; the car's own floor is never recorded
	always_comb begin
		add_tgt = cur_tgt;
		if (fl_q != cur_flr) begin
			add_tgt[fl_q] = 1'b1;
		end
	end

	// one floor step for a busy car, saturating at both ends
	always_comb begin
		nxt_flr = cur_flr;
		if ((cur_dir == DIR_UP) && (cur_flr != TOP_FLOOR)) begin
			nxt_flr = cur_flr + FW'(1);
		end else if ((cur_dir == DIR_DOWN) && (cur_flr != '0)) begin
			nxt_flr = cur_flr - FW'(1);
		end
		arrive   = cur_tgt[nxt_flr];
		tick_tgt = cur_tgt;
		tick_tgt[nxt_flr] = 1'b0;
	end

	// any busy car after the current one still to report
	always_comb begin
		higher_busy = 1'b0;
		for (int c = 0; c < NUM_CARS; c++) begin
			if ((c > int'(cnt_q)) && (car_dir_q[c] != DIR_IDLE)) begin
				higher_busy = 1'b1;
			end
		end
	end

	// output load and car write
	assign out_free = !out_valid_q || res.ready;
	assign load     = out_free && ((state_q == S_ASSIGN) || ((state_q == S_TICK) && cur_busy));
	assign wr_en    = load && ((state_q == S_TICK) || ok_q);
	assign wr_flr   = (state_q == S_TICK) ? nxt_flr : cur_flr;
	assign wr_tgt   = (state_q == S_TICK) ? tick_tgt : add_tgt;

	// result word for the current load
	always_comb begin
		ld_ev  = EV_POSITION;
		ld_idx = CAR_W'(cnt_q);
		if (state_q == S_ASSIGN) begin
			ld_ev = ok_q ? EV_ASSIGNED : EV_UNASSIGNED;
			if (kind_q == KIND_CAR) begin
				ld_idx = car_in_q;
			end else if (!ok_q) begin
				ld_idx = '0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			best_q     <= '0;
			bestd_q    <= '0;
			idle_hit_q <= 1'b0;
			idle_idx_q <= '0;
			ok_q       <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						case (req.kind)
							KIND_HALL: begin
								cnt_q      <= '0;
								hit_q      <= 1'b0;
								idle_hit_q <= 1'b0;
								state_q    <= S_SCAN;
							end
							KIND_CAR: begin
								if (int'(req.car) < NUM_CARS) begin
									cnt_q <= CW'(req.car);
									ok_q  <= 1'b1;
								end else begin
									ok_q  <= 1'b0;
								end
								state_q <= S_ASSIGN;
							end
							KIND_TICK: begin
								cnt_q   <= '0;
								state_q <= S_TICK;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					hit_q      <= hit_n;
					best_q     <= best_n;
					idle_hit_q <= idle_hit_n;
					idle_idx_q <= idle_idx_n;
					if (serves && (!hit_q || (gap < bestd_q))) begin
						bestd_q <= gap;
					end
					if (cnt_q == LAST_CAR) begin
						ok_q    <= hit_n || idle_hit_n;
						cnt_q   <= hit_n ? best_n : idle_idx_n;
						state_q <= S_ASSIGN;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_ASSIGN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (!cur_busy || out_free) begin
						if (cnt_q == LAST_CAR) begin
							state_q <= S_IDLE;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// car state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CARS; c++) begin
				car_flr_q[c] <= '0;
				car_dir_q[c] <= DIR_IDLE;
				car_tgt_q[c] <= '0;
			end
		end else if (wr_en) begin
			car_flr_q[cnt_q] <= wr_flr;
			car_tgt_q[cnt_q] <= wr_tgt;
			car_dir_q[cnt_q] <= dir_of(wr_tgt, wr_flr);
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req.valid) begin
			kind_q   <= req.kind;
			fl_q     <= req_fl;
			dir_q    <= req.dir_down ? DIR_DOWN : DIR_UP;
			car_in_q <= req.car;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (load) begin
			out_ev_q   <= ld_ev;
			out_idx_q  <= ld_idx;
			out_flr_q  <= FLOOR_W'((state_q == S_TICK) ? nxt_flr : fl_q);
			out_stop_q <= (state_q == S_TICK) && arrive;
			out_last_q <= (state_q == S_ASSIGN) || !higher_busy;
		end
	end

	assign req.ready     = (state_q == S_IDLE);
	assign res.valid     = out_valid_q;
	assign res.event_res = out_ev_q;
	assign res.car_index = out_idx_q;
	assign res.at_floor  = out_flr_q;
	assign res.stopped   = out_stop_q;
	assign res.last      = out_last_q;

	// scan index stays within the car range
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cnt_q) <= NUM_CARS - 1)
		else $error("car index out of range");

	// the selected car is idle exactly when it has no targets
	a_idle_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		(car_dir_q[cnt_q] == DIR_IDLE) == (car_tgt_q[cnt_q] == '0))
		else $error("direction disagrees with target set");

	// the selected car keeps no target at its own floor
	a_no_self_tgt: assert property (@(posedge clk) disable iff (!arst_n)
		car_tgt_q[cnt_q][car_flr_q[cnt_q]] == 1'b0)
		else $error("target left at current floor");

	// stop flag only rides on position reports
	a_stop_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.stopped |-> res.event_res == EV_POSITION)
		else $error("stop flag on a call result");

	// a call result is always the final word of its request
	a_call_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && (state_q == S_ASSIGN) |=> out_last_q)
		else $error("call result not marked last");

endmodule

`default_nettype wire
